// ===== design/lpc_pkg.sv =====
// lpc_pkg: shared types, command and result codes for the layered pixel compositor
// used by lpc_addr_unit, lpc_mem and layered_pixel_compositor; no dependencies
package lpc_pkg;

   localparam int DEF_LAYERS = 16;
   localparam int DEF_WIDTH  = 64;
   localparam int DEF_HEIGHT = 64;

   localparam int CMD_W   = 3;
   localparam int COORD_W = 10;
   localparam int LNUM_W  = 5;
   localparam int CHAN_W  = 8;
   localparam int COLOR_W = 3 * CHAN_W;
   localparam int KIND_W  = 2;

   localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SELECT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_FRAME  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

   localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FRAME = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

   typedef logic [COLOR_W-1:0] color_type;

   typedef enum logic [1:0] {
      UOP_PIX  = 2'd0,
      UOP_BASE = 2'd1,
      UOP_DOWN = 2'd2
   } uop_type;

   typedef struct packed {
      logic store_we;
      logic map_we;
   } mem_ctl_type;

endpackage

// ===== design/lpc_addr_unit.sv =====
// lpc_addr_unit: shared multiply-add unit for pixel index and layer store addresses
// depends on lpc_pkg
module lpc_addr_unit #(
   parameter int LAYERS = lpc_pkg::DEF_LAYERS,
   parameter int WIDTH  = lpc_pkg::DEF_WIDTH,
   parameter int HEIGHT = lpc_pkg::DEF_HEIGHT,
   parameter int LAY_W  = 4,
   parameter int PIX_W  = 12,
   parameter int ADDR_W = 16
) (
   input  lpc_pkg::uop_type                op,
   input  logic [lpc_pkg::COORD_W-1:0]     pos_x,
   input  logic [lpc_pkg::COORD_W-1:0]     pos_y,
   input  logic [LAY_W-1:0]                layer,
   input  logic [PIX_W-1:0]                pix,
   input  logic [ADDR_W-1:0]               addr,
   output logic [ADDR_W-1:0]               result
);
   import lpc_pkg::*;

   localparam int PIXELS = WIDTH * HEIGHT;
   localparam logic [ADDR_W-1:0] K_WIDTH = ADDR_W'(WIDTH);
   localparam logic [ADDR_W-1:0] K_PIX   = ADDR_W'(PIXELS);
   localparam logic [ADDR_W-1:0] K_ONE   = ADDR_W'(1);
   localparam logic [ADDR_W-1:0] K_NEG   = ADDR_W'(-PIXELS);

   logic [ADDR_W-1:0] a;
   logic [ADDR_W-1:0] k;
   logic [ADDR_W-1:0] b;

   always_comb begin
      case (op)
         UOP_PIX: begin
            a = ADDR_W'(pos_y);
            k = K_WIDTH;
            b = ADDR_W'(pos_x);
         end
         UOP_BASE: begin
            a = ADDR_W'(layer);
            k = K_PIX;
            b = ADDR_W'(pix);
         end
         UOP_DOWN: begin
            a = addr;
            k = K_ONE;
            b = K_NEG;
         end
         default: begin
            a = '0;
            k = '0;
            b = '0;
         end
      endcase
   end

   assign result = a * k + b;

endmodule

// ===== design/lpc_mem.sv =====
// lpc_mem: layer color store and top layer map, registered reads, clearing pass after reset
// depends on lpc_pkg
module lpc_mem #(
   parameter int LAYERS = lpc_pkg::DEF_LAYERS,
   parameter int WIDTH  = lpc_pkg::DEF_WIDTH,
   parameter int HEIGHT = lpc_pkg::DEF_HEIGHT,
   parameter int LAY_W  = 4,
   parameter int PIX_W  = 12,
   parameter int ADDR_W = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lpc_pkg::mem_ctl_type    ctl,
   input  logic [ADDR_W-1:0]       store_addr,
   input  lpc_pkg::color_type      store_wdata,
   input  logic [PIX_W-1:0]        map_addr,
   input  logic [LAY_W-1:0]        map_wdata,
   output lpc_pkg::color_type      store_q,
   output logic [LAY_W-1:0]        map_q,
   output logic                    busy
);
   import lpc_pkg::*;

   localparam int PIXELS      = WIDTH * HEIGHT;
   localparam int STORE_DEPTH = LAYERS * PIXELS;
   localparam logic [ADDR_W-1:0] LAST_PIX   = ADDR_W'(PIXELS - 1);
   localparam logic [ADDR_W-1:0] LAST_STORE = ADDR_W'(STORE_DEPTH - 1);

   color_type          store_mem [STORE_DEPTH];
   logic [LAY_W-1:0]   map_mem   [PIXELS];

   logic               busy_ff, busy_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   color_type          store_q_ff;
   logic [LAY_W-1:0]   map_q_ff;

   always_comb begin
      busy_in = busy_ff;
      clr_in  = clr_ff;
      if (busy_ff) begin
         if (clr_ff == LAST_STORE) begin
            busy_in = 1'b0;
         end else begin
            clr_in = clr_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         clr_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         clr_ff  <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         store_mem[clr_ff] <= '0;
      end else if (ctl.store_we) begin
         store_mem[store_addr] <= store_wdata;
      end
      store_q_ff <= store_mem[store_addr];
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         if (clr_ff <= LAST_PIX) begin
            map_mem[clr_ff[PIX_W-1:0]] <= '0;
         end
      end else if (ctl.map_we) begin
         map_mem[map_addr] <= map_wdata;
      end
      map_q_ff <= map_mem[map_addr];
   end

   assign store_q = store_q_ff;
   assign map_q   = map_q_ff;
   assign busy    = busy_ff;

endmodule

// ===== design/layered_pixel_compositor.sv =====
// layered_pixel_compositor: top level, command sequencer and result register
// write, clear, read: pix, map, check, walk and data per layer walked on black (read: once), emit
// throughput: one beat at a time; the memory read port, the shared address unit and rsp_stall set the pace
// reset: after reset a clearing pass over every store address blanks both memories,
// req_stall stays high meanwhile; active layer and frame change flag reset to zero
// depends on lpc_pkg, lpc_addr_unit, lpc_mem
module layered_pixel_compositor #(
   parameter int LAYERS = lpc_pkg::DEF_LAYERS,
   parameter int WIDTH  = lpc_pkg::DEF_WIDTH,
   parameter int HEIGHT = lpc_pkg::DEF_HEIGHT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [lpc_pkg::CMD_W-1:0]     req_cmd,
   input  logic [lpc_pkg::COORD_W-1:0]   req_pos_x,
   input  logic [lpc_pkg::COORD_W-1:0]   req_pos_y,
   input  logic [lpc_pkg::LNUM_W-1:0]    req_layer_num,
   input  logic [lpc_pkg::CHAN_W-1:0]    req_red,
   input  logic [lpc_pkg::CHAN_W-1:0]    req_green,
   input  logic [lpc_pkg::CHAN_W-1:0]    req_blue,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lpc_pkg::KIND_W-1:0]    rsp_kind,
   output logic [lpc_pkg::COORD_W-1:0]   rsp_out_x,
   output logic [lpc_pkg::COORD_W-1:0]   rsp_out_y,
   output logic [lpc_pkg::CHAN_W-1:0]    rsp_out_red,
   output logic [lpc_pkg::CHAN_W-1:0]    rsp_out_green,
   output logic [lpc_pkg::CHAN_W-1:0]    rsp_out_blue
);
   import lpc_pkg::*;

   localparam int PIXELS      = WIDTH * HEIGHT;
   localparam int STORE_DEPTH = LAYERS * PIXELS;
   localparam int LAY_W  = (LAYERS > 1) ? $clog2(LAYERS) : 1;
   localparam int PIX_W  = (PIXELS > 1) ? $clog2(PIXELS) : 1;
   localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam logic [COORD_W-1:0] MAX_X    = COORD_W'(WIDTH - 1);
   localparam logic [COORD_W-1:0] MAX_Y    = COORD_W'(HEIGHT - 1);
   localparam logic [LNUM_W-1:0]  LNUM_LIM = LNUM_W'(LAYERS);
   localparam logic [LAY_W-1:0]   TOP_LAY  = LAY_W'(LAYERS - 1);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_PIX   = 7'b0000010,
      ST_MAP   = 7'b0000100,
      ST_CHECK = 7'b0001000,
      ST_WALK  = 7'b0010000,
      ST_DATA  = 7'b0100000,
      ST_EMIT  = 7'b1000000
   } state_type;

   state_type            state_ff, state_in;
   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [COORD_W-1:0]   x_ff, x_in;
   logic [COORD_W-1:0]   y_ff, y_in;
   logic [LAY_W-1:0]     lay_ff, lay_in;
   color_type            color_ff, color_in;
   logic [LAY_W-1:0]     active_ff, active_in;
   logic                 vis_ff, vis_in;
   logic [PIX_W-1:0]     pix_ff, pix_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [KIND_W-1:0]    res_kind_ff, res_kind_in;
   color_type            res_color_ff, res_color_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]    rsp_kind_ff, rsp_kind_in;
   logic [COORD_W-1:0]   rsp_x_ff, rsp_x_in;
   logic [COORD_W-1:0]   rsp_y_ff, rsp_y_in;
   color_type            rsp_color_ff, rsp_color_in;

   uop_type              uop;
   logic [LAY_W-1:0]     unit_layer;
   logic [ADDR_W-1:0]    unit_res;
   mem_ctl_type          ctl;
   color_type            store_q;
   logic [LAY_W-1:0]     map_q;
   logic                 mem_busy;
   logic                 in_range;
   logic                 hit;
   logic                 out_free;
   logic [LAY_W-1:0]     lnum_clamp;

   lpc_addr_unit #(
      .LAYERS (LAYERS),
      .WIDTH  (WIDTH),
      .HEIGHT (HEIGHT),
      .LAY_W  (LAY_W),
      .PIX_W  (PIX_W),
      .ADDR_W (ADDR_W)
   ) u_addr (
      .op     (uop),
      .pos_x  (x_ff),
      .pos_y  (y_ff),
      .layer  (unit_layer),
      .pix    (pix_ff),
      .addr   (addr_ff),
      .result (unit_res)
   );

   lpc_mem #(
      .LAYERS (LAYERS),
      .WIDTH  (WIDTH),
      .HEIGHT (HEIGHT),
      .LAY_W  (LAY_W),
      .PIX_W  (PIX_W),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .store_addr  (addr_ff),
      .store_wdata (color_ff),
      .map_addr    (pix_ff),
      .map_wdata   (lay_ff),
      .store_q     (store_q),
      .map_q       (map_q),
      .busy        (mem_busy)
   );

   assign req_stall  = mem_busy || (state_ff != ST_IDLE);
   assign in_range   = (req_pos_x <= MAX_X) && (req_pos_y <= MAX_Y);
   assign lnum_clamp = (req_layer_num >= LNUM_LIM) ? TOP_LAY : req_layer_num[LAY_W-1:0];
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      lay_in       = lay_ff;
      color_in     = color_ff;
      active_in    = active_ff;
      vis_in       = vis_ff;
      pix_in       = pix_ff;
      addr_in      = addr_ff;
      res_kind_in  = res_kind_ff;
      res_color_in = res_color_ff;
      uop          = UOP_PIX;
      unit_layer   = lay_ff;
      ctl          = '0;
      hit          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !mem_busy) begin
               cmd_in   = req_cmd;
               x_in     = req_pos_x;
               y_in     = req_pos_y;
               lay_in   = active_ff;
               color_in = {req_red, req_green, req_blue};
               case (req_cmd)
                  CMD_WRITE: begin
                     if (in_range) begin
                        state_in = ST_PIX;
                     end
                  end
                  CMD_SELECT: begin
                     active_in = lnum_clamp;
                  end
                  CMD_FRAME: begin
                     if (vis_ff) begin
                        vis_in       = 1'b0;
                        x_in         = '0;
                        y_in         = '0;
                        res_kind_in  = KIND_FRAME;
                        res_color_in = '0;
                        state_in     = ST_EMIT;
                     end
                  end
                  CMD_CLEAR: begin
                     lay_in   = lnum_clamp;
                     color_in = '0;
                     if (in_range) begin
                        state_in = ST_PIX;
                     end
                  end
                  CMD_READ: begin
                     if (in_range) begin
                        state_in = ST_PIX;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PIX: begin
            uop      = UOP_PIX;
            pix_in   = unit_res[PIX_W-1:0];
            state_in = ST_MAP;
         end
         ST_MAP: begin
            uop      = UOP_BASE;
            addr_in  = unit_res;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (cmd_ff == CMD_READ) begin
               unit_layer = map_q;
               uop        = UOP_BASE;
               addr_in    = unit_res;
               state_in   = ST_WALK;
            end else begin
               ctl.store_we = 1'b1;
               hit = (cmd_ff == CMD_WRITE) ? (lay_ff >= map_q) : (lay_ff == map_q);
               if (!hit) begin
                  state_in = ST_IDLE;
               end else begin
                  vis_in = 1'b1;
                  if ((color_ff != '0) || (lay_ff == '0)) begin
                     ctl.map_we   = 1'b1;
                     res_kind_in  = KIND_DRAW;
                     res_color_in = color_ff;
                     state_in     = ST_EMIT;
                  end else begin
                     lay_in   = lay_ff - LAY_W'(1);
                     uop      = UOP_DOWN;
                     addr_in  = unit_res;
                     state_in = ST_WALK;
                  end
               end
            end
         end
         ST_WALK: begin
            state_in = ST_DATA;
         end
         ST_DATA: begin
            if (cmd_ff == CMD_READ) begin
               res_kind_in  = KIND_READ;
               res_color_in = store_q;
               state_in     = ST_EMIT;
            end else if ((store_q != '0) || (lay_ff == '0)) begin
               ctl.map_we   = 1'b1;
               res_kind_in  = KIND_DRAW;
               res_color_in = store_q;
               state_in     = ST_EMIT;
            end else begin
               lay_in   = lay_ff - LAY_W'(1);
               uop      = UOP_DOWN;
               addr_in  = unit_res;
               state_in = ST_WALK;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_color_in = rsp_color_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == ST_EMIT) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = res_kind_ff;
         rsp_x_in     = x_ff;
         rsp_y_in     = y_ff;
         rsp_color_in = res_color_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         vis_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         vis_ff       <= vis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      lay_ff       <= lay_in;
      color_ff     <= color_in;
      pix_ff       <= pix_in;
      addr_ff      <= addr_in;
      res_kind_ff  <= res_kind_in;
      res_color_ff <= res_color_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_color_ff <= rsp_color_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_out_x     = rsp_x_ff;
   assign rsp_out_y     = rsp_y_ff;
   assign rsp_out_red   = rsp_color_ff[3*CHAN_W-1:2*CHAN_W];
   assign rsp_out_green = rsp_color_ff[2*CHAN_W-1:CHAN_W];
   assign rsp_out_blue  = rsp_color_ff[CHAN_W-1:0];

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for layered_pixel_compositor, with its own model of the
// layer planes and top-layer map, a paced driver, a stalling receiver and a beat checker
// depends on lpc_pkg and layered_pixel_compositor
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lpc_pkg::*;

   localparam int TB_LAYERS    = DEF_LAYERS;
   localparam int TB_WIDTH     = DEF_WIDTH;
   localparam int TB_HEIGHT    = DEF_HEIGHT;
   localparam int PIXELS       = TB_WIDTH * TB_HEIGHT;
   localparam int RANDOM_ITEMS = 600;
   localparam int TAIL_CYCLES  = 200;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int REPORT_CAP   = 40;

   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [LNUM_W-1:0]  layer;
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
   } pixel_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
   } pixel_beat_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [CMD_W-1:0]    req_cmd;
   logic [COORD_W-1:0]  req_pos_x;
   logic [COORD_W-1:0]  req_pos_y;
   logic [LNUM_W-1:0]   req_layer_num;
   logic [CHAN_W-1:0]   req_red;
   logic [CHAN_W-1:0]   req_green;
   logic [CHAN_W-1:0]   req_blue;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [KIND_W-1:0]   rsp_kind;
   logic [COORD_W-1:0]  rsp_out_x;
   logic [COORD_W-1:0]  rsp_out_y;
   logic [CHAN_W-1:0]   rsp_out_red;
   logic [CHAN_W-1:0]   rsp_out_green;
   logic [CHAN_W-1:0]   rsp_out_blue;

   // model state
   color_type           plane_store [PIXELS*TB_LAYERS];
   logic [LNUM_W-1:0]   top_map [PIXELS];
   int                  cur_layer;
   bit                  frame_dirty;

   pixel_cmd_type       pending_cmds[$];
   pixel_beat_type      expected_beats[$];
   int                  gen_layer;
   int                  total_cmds;
   int                  accepted_count;
   int                  error_count;
   int                  draw_seen;
   int                  frame_seen;
   int                  read_seen;
   int                  cycle_count;
   logic                req_took;

   layered_pixel_compositor u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_layer_num (req_layer_num),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= REPORT_CAP) begin
         $display("tb_top: mismatch at cycle %0d: %s", cycle_count, msg);
      end
   endtask

   // store a color in one layer and work out the display write, if any
   function automatic bit paint_layer(input int x, input int y, input int lay,
                                      input color_type colour, output pixel_beat_type b);
      int        pix;
      int        walk;
      color_type shown;
      pix   = y * TB_WIDTH + x;
      walk  = lay;
      shown = colour;
      b     = '0;
      plane_store[lay*PIXELS + pix] = colour;
      if (lay < int'(top_map[pix])) begin
         return 1'b0;
      end
      frame_dirty = 1'b1;
      if (colour == '0) begin
         while (walk > 0 && plane_store[walk*PIXELS + pix] == '0) begin
            walk--;
         end
         shown = plane_store[walk*PIXELS + pix];
      end
      top_map[pix] = walk[LNUM_W-1:0];
      b.kind  = KIND_DRAW;
      b.x     = x[COORD_W-1:0];
      b.y     = y[COORD_W-1:0];
      b.red   = shown[23:16];
      b.green = shown[15:8];
      b.blue  = shown[7:0];
      return 1'b1;
   endfunction

   function automatic bit composite_step(input pixel_cmd_type c, output pixel_beat_type b);
      int        lay;
      int        pix;
      bit        in_frame;
      color_type shown;
      lay      = (int'(c.layer) >= TB_LAYERS) ? TB_LAYERS - 1 : int'(c.layer);
      in_frame = (int'(c.x) < TB_WIDTH) && (int'(c.y) < TB_HEIGHT);
      pix      = int'(c.y) * TB_WIDTH + int'(c.x);
      b        = '0;
      case (c.cmd)
         CMD_WRITE: begin
            if (!in_frame) return 1'b0;
            return paint_layer(int'(c.x), int'(c.y), cur_layer,
                               {c.red, c.green, c.blue}, b);
         end
         CMD_SELECT: begin
            cur_layer = lay;
            return 1'b0;
         end
         CMD_FRAME: begin
            if (!frame_dirty) return 1'b0;
            frame_dirty = 1'b0;
            b.kind = KIND_FRAME;
            return 1'b1;
         end
         CMD_CLEAR: begin
            if (!in_frame) return 1'b0;
            if (int'(top_map[pix]) == lay) begin
               return paint_layer(int'(c.x), int'(c.y), lay, '0, b);
            end
            plane_store[lay*PIXELS + pix] = '0;
            return 1'b0;
         end
         CMD_READ: begin
            if (!in_frame) return 1'b0;
            shown   = plane_store[int'(top_map[pix])*PIXELS + pix];
            b.kind  = KIND_READ;
            b.x     = c.x;
            b.y     = c.y;
            b.red   = shown[23:16];
            b.green = shown[15:8];
            b.blue  = shown[7:0];
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   task automatic check_beat(input pixel_beat_type got);
      pixel_beat_type want;
      if (expected_beats.size() == 0) begin
         report_mismatch($sformatf("beat with nothing pending: kind %0d x %0d y %0d",
                                   got.kind, got.x, got.y));
         return;
      end
      want = expected_beats.pop_front();
      if (got.kind !== want.kind)
         report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.x !== want.x)
         report_mismatch($sformatf("out_x %0d, want %0d", got.x, want.x));
      if (got.y !== want.y)
         report_mismatch($sformatf("out_y %0d, want %0d", got.y, want.y));
      if (got.red !== want.red)
         report_mismatch($sformatf("out_red %h, want %h", got.red, want.red));
      if (got.green !== want.green)
         report_mismatch($sformatf("out_green %h, want %h", got.green, want.green));
      if (got.blue !== want.blue)
         report_mismatch($sformatf("out_blue %h, want %h", got.blue, want.blue));
   endtask

   task automatic push_cmd(input logic [CMD_W-1:0] cmd, input int x, input int y,
                           input int layer, input color_type colour);
      pixel_cmd_type c;
      c.cmd   = cmd;
      c.x     = x[COORD_W-1:0];
      c.y     = y[COORD_W-1:0];
      c.layer = layer[LNUM_W-1:0];
      c.red   = colour[23:16];
      c.green = colour[15:8];
      c.blue  = colour[7:0];
      // track the selected layer so clears can aim at it
      if (cmd == CMD_SELECT) begin
         gen_layer = (layer >= TB_LAYERS) ? TB_LAYERS - 1 : layer;
      end
      pending_cmds = {pending_cmds, c};
   endtask

   // each coordinate mostly near either end, so layers stack up in the corners; some are out of range
   function automatic int pick_coord(input int limit);
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return $urandom_range(0, 2);
      if (r < 70) return $urandom_range(limit - 3, limit - 1);
      if (r < 93) return $urandom_range(0, limit - 1);
      return $urandom_range(limit, 1023);
   endfunction

   task automatic gen_random_cmds(input int count);
      int                r;
      int                rc;
      int                layer;
      color_type         colour;
      logic [CMD_W-1:0]  cmd;
      for (int i = 0; i < count; i++) begin
         r  = $urandom_range(0, 99);
         rc = $urandom_range(0, 99);
         if (rc < 35) colour = '0;
         else if (rc < 45) colour = color_type'(1) << $urandom_range(0, COLOR_W - 1);
         else colour = color_type'($urandom);
         layer = ($urandom_range(0, 99) < 75) ? $urandom_range(0, TB_LAYERS - 1)
                                              : $urandom_range(TB_LAYERS, 31);
         if (r < 40) cmd = CMD_WRITE;
         else if (r < 55) cmd = CMD_SELECT;
         else if (r < 65) cmd = CMD_FRAME;
         else if (r < 78) begin
            cmd = CMD_CLEAR;
            if ($urandom_range(0, 1) == 0) layer = gen_layer;
         end
         else if (r < 96) cmd = CMD_READ;
         else cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
         push_cmd(cmd, pick_coord(TB_WIDTH), pick_coord(TB_HEIGHT), layer, colour);
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_cmd       = '0;
      req_pos_x     = '0;
      req_pos_y     = '0;
      req_layer_num = '0;
      req_red       = '0;
      req_green     = '0;
      req_blue      = '0;
      rsp_stall     = 1'b0;
      req_took      = 1'b0;
      cur_layer     = 0;
      frame_dirty   = 1'b0;
      gen_layer     = 0;
      for (int i = 0; i < PIXELS*TB_LAYERS; i++) plane_store[i] = '0;
      for (int i = 0; i < PIXELS; i++) top_map[i] = '0;

      // directed opening
      push_cmd(CMD_READ,   0, 0, 0, 24'h000000);
      push_cmd(CMD_WRITE,  0, 0, 0, 24'hFFFFFF);
      push_cmd(CMD_FRAME,  0, 0, 0, 24'h000000);
      push_cmd(CMD_FRAME,  0, 0, 0, 24'h000000);
      push_cmd(CMD_SELECT, 0, 0, 31, 24'h000000);
      push_cmd(CMD_WRITE,  TB_WIDTH - 1, TB_HEIGHT - 1, 0, 24'h123456);
      push_cmd(CMD_WRITE,  TB_WIDTH, 0, 0, 24'hFFFFFF);
      push_cmd(CMD_WRITE,  0, 1023, 0, 24'hFFFFFF);
      push_cmd(CMD_SELECT, 0, 0, 0, 24'h000000);
      push_cmd(CMD_WRITE,  TB_WIDTH - 1, TB_HEIGHT - 1, 0, 24'hAABBCC);
      push_cmd(CMD_SELECT, 0, 0, TB_LAYERS - 1, 24'h000000);
      push_cmd(CMD_WRITE,  TB_WIDTH - 1, TB_HEIGHT - 1, 0, 24'h000000);
      push_cmd(CMD_READ,   TB_WIDTH - 1, TB_HEIGHT - 1, 0, 24'h000000);
      push_cmd(CMD_SELECT, 0, 0, 5, 24'h000000);
      push_cmd(CMD_WRITE,  1, 1, 0, 24'hFF0000);
      push_cmd(CMD_SELECT, 0, 0, 9, 24'h000000);
      push_cmd(CMD_WRITE,  1, 1, 0, 24'h00FF00);
      push_cmd(CMD_CLEAR,  1, 1, 5, 24'h000000);
      push_cmd(CMD_CLEAR,  1, 1, 9, 24'h000000);
      push_cmd(CMD_CLEAR,  2, 2, 31, 24'h000000);
      push_cmd(CMD_CLEAR,  1023, 0, 0, 24'h000000);
      for (int k = CMD_SPARE_LO; k <= CMD_SPARE_HI; k++) begin
         push_cmd(CMD_W'(k), 0, 0, 0, 24'hFFFFFF);
      end
      push_cmd(CMD_READ,   1023, 1023, 31, 24'h000000);
      push_cmd(CMD_FRAME,  0, 0, 0, 24'h000000);
      push_cmd(CMD_WRITE,  0, 0, 0, 24'h000000);

      gen_random_cmds(RANDOM_ITEMS);
      total_cmds = pending_cmds.size();

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (accepted_count < total_cmds) @(negedge clock);
      while (expected_beats.size() > 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("tb_top: %0d commands sent, beats checked: %0d draw, %0d frame, %0d read",
               accepted_count, draw_seen, frame_seen, read_seen);
      $display("tb_top: %0d mismatches", error_count);
      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   always @(negedge clock) begin : req_driver
      pixel_cmd_type c;
      int            r;
      int            req_gap;
      int            req_calm;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   = 0;
         req_calm  = 0;
      end else if (!req_valid || req_took) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_cmds.size() > 0) begin
            c = pending_cmds.pop_front();
            req_cmd       <= c.cmd;
            req_pos_x     <= c.x;
            req_pos_y     <= c.y;
            req_layer_num <= c.layer;
            req_red       <= c.red;
            req_green     <= c.green;
            req_blue      <= c.blue;
            req_valid     <= 1'b1;
            r = $urandom_range(0, 99);
            if (req_calm > 0) begin
               req_calm--;
               req_gap = 0;
            end else if (r < 3) begin
               req_calm = $urandom_range(15, 60);
               req_gap  = 0;
            end else if (r < 50) req_gap = 0;
            else if (r < 90) req_gap = $urandom_range(1, 3);
            else if (r < 97) req_gap = $urandom_range(4, 12);
            else req_gap = $urandom_range(20, 60);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : rsp_pacer
      int r;
      int rsp_hold;
      int rsp_calm;
      r = $urandom_range(0, 99);
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
         rsp_calm = 0;
      end else if (rsp_calm > 0) begin
         rsp_calm--;
         rsp_stall <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_stall <= 1'b1;
      end else if (r < 3) begin
         rsp_calm = $urandom_range(20, 80);
         rsp_stall <= 1'b0;
      end else if (r < 30) begin
         rsp_hold = $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else if (r < 32) begin
         rsp_hold = $urandom_range(10, 40);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : beat_monitor
      pixel_cmd_type  c;
      pixel_beat_type want;
      pixel_beat_type got;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: timed out with %0d beats pending", expected_beats.size());
         $display("tb_top: done, errors");
         $finish;
      end else begin
         req_took <= !reset && req_valid && !req_stall;
         if (!reset && rsp_valid && !rsp_stall) begin
            got = {rsp_kind, rsp_out_x, rsp_out_y, rsp_out_red, rsp_out_green,
                   rsp_out_blue};
            check_beat(got);
            case (got.kind)
               KIND_DRAW:  draw_seen++;
               KIND_FRAME: frame_seen++;
               KIND_READ:  read_seen++;
               default:    ;
            endcase
         end
         if (!reset && req_valid && !req_stall) begin
            c = {req_cmd, req_pos_x, req_pos_y, req_layer_num, req_red, req_green,
                 req_blue};
            if (composite_step(c, want)) expected_beats = {expected_beats, want};
            accepted_count++;
         end
      end
   end

endmodule
